// ----- design/tcc_pkg.sv -----
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_WIDTH      = 8;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(SCREEN_COLUMNS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_CELL_ATTR = '0;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_end;
    } in_beat_t;

    typedef struct packed {
        logic             action;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_column;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             last_result;
    } out_beat_t;

    typedef enum logic [1:0] {
        CMD_PRINT,
        CMD_CR,
        CMD_LF,
        CMD_TAB
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TAB,
        BK_SCROLL
    } back_state_t;

endpackage

// ----- design/tcc_front.sv -----
// Front end: accepts character beats and classifies them into commands.
module tcc_front
    import tcc_pkg::*;
(
    input  logic     in_valid,
    input  in_beat_t in_data,
    input  logic     q_full,
    output logic     in_stall,
    output logic     push,
    output cmd_t     push_cmd
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd.code = in_data.char_code;
        unique case (in_data.char_code)
            CHAR_CR:  push_cmd.kind = CMD_CR;
            CHAR_LF:  push_cmd.kind = CMD_LF;
            CHAR_TAB: push_cmd.kind = CMD_TAB;
            default:  push_cmd.kind = CMD_PRINT;
        endcase
    end

endmodule

// ----- design/tcc_queue.sv -----
// Short command queue between the front end and the sequencer.
module tcc_queue
    import tcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> !pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- design/tcc_back.sv -----
// Back end: cursor sequencer that emits cell writes and scrolls, one beat a cycle while the output is not stalled.
module tcc_back
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    input  logic [7:0] attr,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output out_beat_t  out_data
);

    back_state_t      state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_beat_reg, out_beat_next;

    logic             out_free;
    logic [COL_W-1:0] ncol;
    logic             tab_more;
    logic             wrap;
    logic             on_last;
    logic             wrap_scroll;
    logic             do_write;
    logic             write_tab;
    logic [7:0]       write_char;
    logic             emit;
    out_beat_t        beat;

    assign out_free    = !out_valid_reg || !out_stall;
    assign ncol        = col_reg + 1'b1;
    assign tab_more    = ((ncol % TAB_WIDTH) != 0) && (ncol < COL_LIMIT);
    assign wrap        = ncol >= COL_LIMIT;
    assign on_last     = row_reg == LAST_ROW;
    assign wrap_scroll = wrap && on_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    unique case (head.cmd.kind)
                        CMD_TAB:   state_next = tab_more ? BK_TAB :
                                                (wrap_scroll ? BK_SCROLL : BK_IDLE);
                        CMD_PRINT: state_next = wrap_scroll ? BK_SCROLL : BK_IDLE;
                        CMD_CR:    state_next = BK_IDLE;
                        CMD_LF:    state_next = BK_IDLE;
                    endcase
                end
            end
            BK_TAB:
            begin
                if (out_free)
                begin
                    state_next = tab_more ? BK_TAB : (wrap_scroll ? BK_SCROLL : BK_IDLE);
                end
            end
            BK_SCROLL:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        row_next   = row_reg;
        col_next   = col_reg;
        do_write   = 1'b0;
        write_tab  = 1'b0;
        write_char = CHAR_SPACE;
        emit       = 1'b0;
        beat       = '{action: ACT_SCROLL, cell_row: '0, cell_column: '0,
                       cell_char: '0, cell_attr: '0, last_result: 1'b1};
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.kind)
                        CMD_CR:
                        begin
                            col_next = '0;
                        end
                        CMD_LF:
                        begin
                            col_next = '0;
                            if (on_last)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        CMD_TAB:
                        begin
                            do_write  = 1'b1;
                            write_tab = 1'b1;
                        end
                        CMD_PRINT:
                        begin
                            do_write   = 1'b1;
                            write_char = head.cmd.code;
                        end
                    endcase
                end
            end
            BK_TAB:
            begin
                if (out_free)
                begin
                    do_write  = 1'b1;
                    write_tab = 1'b1;
                end
            end
            BK_SCROLL:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_write)
        begin
            emit = 1'b1;
            beat = '{action: ACT_WRITE, cell_row: row_reg, cell_column: col_reg,
                     cell_char: write_char, cell_attr: attr, last_result: 1'b1};
            if (write_tab && tab_more)
            begin
                col_next         = ncol;
                beat.last_result = 1'b0;
            end
            else if (wrap)
            begin
                col_next = '0;
                if (on_last)
                begin
                    beat.last_result = 1'b0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = ncol;
            end
        end

        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_beat_next  = beat;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= LAST_ROW) else $error("cursor row past last row");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_LIMIT) else $error("cursor column past last column");
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_SCROLL |-> row_reg == LAST_ROW && col_reg == '0)
        else $error("pending scroll away from last row start");
    a_tab_col: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_TAB |-> (col_reg % TAB_WIDTH) != 0)
        else $error("tab fill on a tab stop");
    a_scroll_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.action == ACT_SCROLL
        |-> out_beat_reg.last_result && out_beat_reg.cell_row == '0
            && out_beat_reg.cell_column == '0)
        else $error("scroll beat malformed");

endmodule

// ----- design/text_console_cursor_engine.sv -----
// Text console cursor engine top level: register port, front end, queue and sequencer.
// An input beat is held in the command queue; its result beats leave through the output register.
// The sequencer emits its result beats one by one and waits while the output is stalled; CR or a plain LF
// gives none, and a tab writes spaces up to the next tab stop or the line end, then any scroll.
// The two-entry command queue lets input be taken while the sequencer is busy.
// Reset: cursor at row 0 column 0, attribute 0x07, queue and output empty.
module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_beat_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_beat_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       attr_we;
    logic [7:0] attr_value_reg, attr_value_next;
    logic       q_full;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    q_head_t    head;

    assign pready  = 1'b1;
    assign attr_we = psel && penable && pwrite && (paddr == ADDR_CELL_ATTR);
    assign attr_value_next = attr_we ? pwdata[7:0] : attr_value_reg;
    assign prdata = (paddr == ADDR_CELL_ATTR) ? {(PDATA_W - 8)'(0), attr_value_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_value_reg <= ATTR_RESET;
        end
        else
        begin
            attr_value_reg <= attr_value_next;
        end
    end

    tcc_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    tcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .attr      (attr_value_reg),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the text console cursor engine: cursor tracking, tab fill, scrolls.
`timescale 1ns / 1ps

module tb_top;
    import tcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CALM_SPAN     = 40;

    class cursor_scoreboard;
        logic [ROW_W-1:0] cur_row;
        logic [COL_W-1:0] cur_col;
        logic [7:0]       attr_byte;
        out_beat_t        cells_due[$];
        int unsigned      errors;

        function new();
            cur_row   = '0;
            cur_col   = '0;
            attr_byte = ATTR_RESET;
            errors    = 0;
        endfunction

        function void set_attr(logic [7:0] value);
            attr_byte = value;
        endfunction

        function int pending();
            return cells_due.size();
        endfunction

        function out_beat_t make_beat(logic act, int r, int c, logic [7:0] ch, logic [7:0] a);
            out_beat_t b;
            b.action      = act;
            b.cell_row    = ROW_W'(r);
            b.cell_column = COL_W'(c);
            b.cell_char   = ch;
            b.cell_attr   = a;
            b.last_result = 1'b0;
            return b;
        endfunction

        function void note_char(in_beat_t beat);
            int        r;
            int        c;
            out_beat_t made[$];
            out_beat_t tail;
            r = cur_row;
            c = cur_col;
            case (beat.char_code)
                CHAR_CR: c = 0;
                CHAR_LF:
                begin
                    r++;
                    c = 0;
                end
                CHAR_TAB:
                begin
                    do
                    begin
                        made.push_back(make_beat(ACT_WRITE, r, c, CHAR_SPACE, attr_byte));
                        c++;
                    end while ((c % TAB_WIDTH) != 0 && c < SCREEN_COLUMNS);
                end
                default:
                begin
                    made.push_back(make_beat(ACT_WRITE, r, c, beat.char_code, attr_byte));
                    c++;
                end
            endcase
            if (c >= SCREEN_COLUMNS)
            begin
                c = 0;
                r++;
            end
            if (r >= SCREEN_ROWS)
            begin
                made.push_back(make_beat(ACT_SCROLL, 0, 0, 8'h00, 8'h00));
                r = SCREEN_ROWS - 1;
            end
            if (made.size() > 0)
            begin
                tail = made[made.size() - 1];
                tail.last_result = 1'b1;
                made[made.size() - 1] = tail;
            end
            foreach (made[i])
                cells_due.push_back(made[i]);
            cur_row = ROW_W'(r);
            cur_col = COL_W'(c);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (cells_due.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = cells_due.pop_front();
            compare_field("action", want.action, got.action);
            compare_field("cell_row", want.cell_row, got.cell_row);
            compare_field("cell_column", want.cell_column, got.cell_column);
            compare_field("cell_char", want.cell_char, got.cell_char);
            compare_field("cell_attr", want.cell_attr, got.cell_attr);
            compare_field("last_result", want.last_result, got.last_result);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_beat_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_beat_t          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cursor_scoreboard sb = new();
    int unsigned      chars_sent = 0;
    int unsigned      beats_taken = 0;
    int unsigned      cycles = 0;
    bit               calm_in = 1'b0;
    bit               calm_out = 1'b0;

    text_console_cursor_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_beat(out_data);
            if (in_valid && !in_stall)
                sb.note_char(in_data);
        end
    end

    initial
    begin
        int unsigned hold;
        wait (rst_n);
        forever
        begin
            if (beats_taken % CALM_SPAN == 0)
                calm_out = ($urandom_range(0, 3) == 0);
            hold = calm_out ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            beats_taken++;
        end
    end

    task automatic send_char(input logic [7:0] code, input logic mark);
        int unsigned gap;
        in_beat_t    beat;
        if (chars_sent % CALM_SPAN == 0)
            calm_in = ($urandom_range(0, 3) == 0);
        gap = calm_in ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.char_code = code;
        beat.string_end = mark;
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            while (sb.pending() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end while (sb.pending() != 0);
    endtask

    task automatic write_attr(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CELL_ATTR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_attr(value);
    endtask

    function automatic logic [7:0] printable_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF || c == CHAR_TAB);
        return c;
    endfunction

    task automatic random_lines(input int unsigned item_cap, input bit stop_on_last_row);
        int unsigned pick;
        int unsigned len;
        while (chars_sent < item_cap && !(stop_on_last_row && sb.cur_row == LAST_ROW))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                len = ($urandom_range(0, 99) < 7) ? $urandom_range(60, 95) : $urandom_range(0, 6);
                for (int unsigned i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        send_char(CHAR_TAB, 1'($urandom_range(0, 1)));
                    else
                        send_char(printable_code(), i == len - 1);
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_char(CHAR_CR, 1'b0);
                        send_char(CHAR_LF, 1'b1);
                    end
                    1: send_char(CHAR_LF, 1'($urandom_range(0, 1)));
                    2:
                    begin
                        send_char(CHAR_LF, 1'b0);
                        send_char(CHAR_CR, 1'($urandom_range(0, 1)));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CHAR_TAB, 1'b0);
        send_char(CHAR_TAB, 1'b1);
        send_char(8'h7F, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(CHAR_CR, 1'b0);
        send_char(CHAR_TAB, 1'b0);
        send_char(CHAR_LF, 1'b1);
        send_char(CHAR_LF, 1'b0);
        send_char(CHAR_CR, 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        send_char(8'h41, 1'b1);

        settle();
        write_attr(8'h00);
        random_lines(260, 1'b1);

        settle();
        write_attr(8'hFF);
        send_char(CHAR_CR, 1'b0);
        repeat (10) send_char(CHAR_TAB, 1'b0);
        send_char(CHAR_LF, 1'b1);
        send_char(CHAR_LF, 1'b0);
        random_lines(340, 1'b0);

        settle();
        write_attr(8'($urandom_range(1, 254)));
        random_lines(420, 1'b0);

        settle();
        if (sb.pending() != 0)
            $error("%0d expected result beats never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tcc_pkg.sv
design/tcc_front.sv
design/tcc_queue.sv
design/tcc_back.sv
design/text_console_cursor_engine.sv
tb/tb_top.sv
